// ===== hdl/mean_squared_displacement_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the displacement block.
// ----------------------------------------------------------------------------
`ifndef MEAN_SQUARED_DISPLACEMENT_MACROS_SVH
`define MEAN_SQUARED_DISPLACEMENT_MACROS_SVH

// same-cycle implication
`define MSD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define MSD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Types and fixed constants of the mean squared displacement block.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int POS_W  = 32;
  localparam int MAG_W  = POS_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int ACC_W  = 96;
  localparam int NUM_W  = 128;
  localparam int VAL_W  = 63;
  localparam int FRM_W  = 6;
  localparam int TAU_W  = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  localparam logic [2:0] REG_TYPE    = 3'd0;
  localparam logic [2:0] REG_LFIRST  = 3'd1;
  localparam logic [2:0] REG_LLAST   = 3'd2;
  localparam logic [2:0] REG_LSTRIDE = 3'd3;
  localparam logic [2:0] REG_FFIRST  = 3'd4;
  localparam logic [2:0] REG_FLAST   = 3'd5;
  localparam logic [2:0] REG_FSTRIDE = 3'd6;
  localparam logic [2:0] REG_STATUS  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAG_START,
    ST_ISSUE,
    ST_DRAIN,
    ST_SCALE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/msd_ram.sv =====
// ----------------------------------------------------------------------------
// msd_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module msd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/msd_lane.sv =====
// ----------------------------------------------------------------------------
// msd_lane
// One coordinate lane: position store, displacement and square.
// ----------------------------------------------------------------------------
module msd_lane #(
  parameter int DEPTH = 16384
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [msd_pkg::POS_W-1:0]   wdata,
  input  logic [$clog2(DEPTH)-1:0]    raddr_a,
  input  logic [$clog2(DEPTH)-1:0]    raddr_b,
  output logic [msd_pkg::SQ_W-1:0]    sq
);

  logic [msd_pkg::POS_W-1:0] rd_a;
  logic [msd_pkg::POS_W-1:0] rd_b;
  logic [msd_pkg::MAG_W-1:0] diff;
  logic [msd_pkg::MAG_W-1:0] mag;

  msd_ram #(
    .WIDTH (msd_pkg::POS_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign diff = {rd_a[msd_pkg::POS_W-1], rd_a} - {rd_b[msd_pkg::POS_W-1], rd_b};

  always_ff @(posedge clk) begin
    mag <= diff[msd_pkg::MAG_W-1] ? (~diff + 1'b1) : diff;
    sq  <= mag * mag;
  end

endmodule

// ===== hdl/msd_div.sv =====
// ----------------------------------------------------------------------------
// msd_div
// Restoring divider, one quotient bit per cycle, saturated 63-bit result.
// ----------------------------------------------------------------------------
module msd_div #(
  parameter int DEN_W = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [msd_pkg::NUM_W-1:0]  num_in,
  input  logic [DEN_W-1:0]           den_in,
  output logic                       done,
  output logic [msd_pkg::VAL_W-1:0]  quot
);

  localparam int CNT_W = $clog2(msd_pkg::NUM_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [msd_pkg::NUM_W-1:0] num;
  logic [DEN_W-1:0]          den;
  logic [DEN_W:0]            rem;
  logic [DEN_W:0]            rem_sh;
  logic                      q_bit;

  assign rem_sh = {rem[DEN_W-1:0], num[msd_pkg::NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '1;
        num  <= num_in;
        den  <= den_in;
        rem  <= '0;
      end else if (busy) begin
        rem <= q_bit ? (rem_sh - {1'b0, den}) : rem_sh;
        num <= {num[msd_pkg::NUM_W-2:0], q_bit};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = (|num[msd_pkg::NUM_W-1:msd_pkg::VAL_W]) ? '1 : num[msd_pkg::VAL_W-1:0];

endmodule

// ===== hdl/mean_squared_displacement.sv =====
// ----------------------------------------------------------------------------
// mean_squared_displacement
// Time-averaged MSD over a stored trajectory, three coordinate lanes merged.
//
//   channel | dir | handshake        | payload
//   config  | in  | psel/penable     | paddr, pwdata, prdata
//   request | in  | in_valid/ready   | opcode, frame, atom_type, pos_x/y/z
//   result  | out | out_valid/ready  | lag, msd_value, div_error, last_result
//
// Load request: one per cycle back to back, accepted only while the sweep is idle.
// Run request: per lag, the element walk issues one particle (all three
//   coordinates) per cycle, the divider retires one quotient bit per cycle
//   over the 128-bit numerator.
// Reset returns control and configuration to defaults; the store is undefined until loaded.
// A stalled result holds the sweep in its emit step.
// ----------------------------------------------------------------------------
`include "mean_squared_displacement_macros.svh"

module mean_squared_displacement #(
  parameter int MAX_FRAMES    = 64,
  parameter int MAX_PARTICLES = 256,
  parameter int FRAC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [5:0]         frame,
  input  logic [7:0]         atom_type,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         lag,
  output logic [62:0]        msd_value,
  output logic               div_error,
  output logic               last_result
);

  localparam int DEPTH = MAX_FRAMES * MAX_PARTICLES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_PARTICLES + 1);
  localparam int NSH   = (2 * FRAC_BITS <= 32) ? (32 - 2 * FRAC_BITS) : 0;
  localparam int DSH   = (2 * FRAC_BITS > 32) ? (2 * FRAC_BITS - 32) : 0;
  localparam int DEN_W = msd_pkg::TAU_W + CW + DSH;
  localparam logic [msd_pkg::TAU_W-1:0] FLIM = msd_pkg::TAU_W'(MAX_FRAMES - 1);
  localparam logic [AW-1:0] MAXP = AW'(MAX_PARTICLES);
  localparam logic [CW-1:0] CAP  = CW'(MAX_PARTICLES);

  msd_pkg::state_t state, state_next;

  logic [7:0] type_select;
  logic [5:0] lag_first, lag_last, lag_stride;
  logic [5:0] frame_first, frame_last, frame_stride;

  logic [CW-1:0] particle_count;
  logic [5:0]    current_frame;
  logic          store_overflow;

  logic [msd_pkg::TAU_W-1:0] tau, t0, flim, tau_next;
  logic [5:0]                ls, fs, mcnt;
  logic [CW-1:0]             j;
  logic [msd_pkg::TAU_W-1:0] dspan;
  logic                      err;
  logic [3:0]                stg;
  logic [msd_pkg::ACC_W-1:0] acc, merged;
  logic [msd_pkg::NUM_W-1:0] num;

  logic [msd_pkg::SQ_W-1:0] sq_x, sq_y, sq_z;
  logic [8:0]               dspan_c;
  logic                     bad;
  logic                     load_fire, run_fire, cfg_wr, out_free;
  logic                     keep, type_hit, frame_new, we;
  logic [CW-1:0]            cnt_eff;
  logic [AW-1:0]            waddr, raddr_a, raddr_b;
  logic                     last_j, last_origin, first_origin_ok;
  logic [msd_pkg::TAU_W:0]  t0_step;
  logic                     div_done;
  logic [msd_pkg::VAL_W-1:0] div_q;
  logic [DEN_W-1:0]         den;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_ready  = (state == msd_pkg::ST_IDLE);
  assign load_fire = in_valid && in_ready && (opcode == msd_pkg::OP_LOAD);
  assign run_fire  = in_valid && in_ready && (opcode == msd_pkg::OP_RUN);
  assign out_free  = !out_valid || out_ready;

  assign ls   = (lag_stride == '0) ? 6'd1 : lag_stride;
  assign fs   = (frame_stride == '0) ? 6'd1 : frame_stride;
  assign flim = ({1'b0, frame_last} < FLIM) ? {1'b0, frame_last} : FLIM;
  assign tau_next = tau + {1'b0, ls};

  always_ff @(posedge clk) begin
    if (rst) begin
      type_select  <= 8'd1;
      lag_first    <= 6'd1;
      lag_last     <= 6'd10;
      lag_stride   <= 6'd1;
      frame_first  <= 6'd0;
      frame_last   <= 6'd63;
      frame_stride <= 6'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        msd_pkg::REG_TYPE:    type_select  <= pwdata[7:0];
        msd_pkg::REG_LFIRST:  lag_first    <= pwdata[5:0];
        msd_pkg::REG_LLAST:   lag_last     <= pwdata[5:0];
        msd_pkg::REG_LSTRIDE: lag_stride   <= pwdata[5:0];
        msd_pkg::REG_FFIRST:  frame_first  <= pwdata[5:0];
        msd_pkg::REG_FLAST:   frame_last   <= pwdata[5:0];
        msd_pkg::REG_FSTRIDE: frame_stride <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      msd_pkg::REG_TYPE:    prdata = {24'd0, type_select};
      msd_pkg::REG_LFIRST:  prdata = {26'd0, lag_first};
      msd_pkg::REG_LLAST:   prdata = {26'd0, lag_last};
      msd_pkg::REG_LSTRIDE: prdata = {26'd0, lag_stride};
      msd_pkg::REG_FFIRST:  prdata = {26'd0, frame_first};
      msd_pkg::REG_FLAST:   prdata = {26'd0, frame_last};
      msd_pkg::REG_FSTRIDE: prdata = {26'd0, frame_stride};
      default:              prdata = {31'd0, store_overflow};
    endcase
  end

  assign keep      = (frame <= frame_last) && (32'(frame) < 32'(MAX_FRAMES));
  assign frame_new = (frame != current_frame);
  assign type_hit  = (atom_type == type_select);
  assign cnt_eff   = frame_new ? '0 : particle_count;
  assign we        = load_fire && keep && type_hit && (cnt_eff < CAP);
  assign waddr     = AW'(frame) * MAXP + AW'(cnt_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= '0;
      current_frame  <= '0;
      store_overflow <= 1'b0;
    end else if (load_fire && keep) begin
      current_frame <= frame;
      if (type_hit && (cnt_eff < CAP)) begin
        particle_count <= cnt_eff + 1'b1;
      end else begin
        particle_count <= cnt_eff;
        if (type_hit) begin
          store_overflow <= 1'b1;
        end
      end
    end
  end

  assign raddr_a = AW'(t0 + tau) * MAXP + AW'(j);
  assign raddr_b = AW'(t0) * MAXP + AW'(j);

  msd_lane #(.DEPTH(DEPTH)) u_lane_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(pos_x),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .sq(sq_x)
  );

  msd_lane #(.DEPTH(DEPTH)) u_lane_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(pos_y),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .sq(sq_y)
  );

  msd_lane #(.DEPTH(DEPTH)) u_lane_z (
    .clk(clk), .we(we), .waddr(waddr), .wdata(pos_z),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .sq(sq_z)
  );

  assign dspan_c = 9'(frame_last) - 9'(frame_first) + 9'd1 - 9'(tau);
  assign bad     = dspan_c[8] || (dspan_c == '0) || (particle_count == '0);
  assign first_origin_ok = ({1'b0, frame_first} + tau) <= flim;
  assign t0_step     = {1'b0, t0} + {2'b0, fs};
  assign last_j      = (j == particle_count - 1'b1);
  assign last_origin = (t0_step + {1'b0, tau}) > {1'b0, flim};

  assign den = DEN_W'(DEN_W'(dspan) * DEN_W'(particle_count)) << DSH;

  msd_div #(.DEN_W(DEN_W)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == msd_pkg::ST_DIV_START),
    .num_in (num << NSH),
    .den_in (den),
    .done   (div_done),
    .quot   (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      msd_pkg::ST_IDLE: begin
        if (run_fire && (lag_first <= lag_last)) begin
          state_next = msd_pkg::ST_LAG_START;
        end
      end
      msd_pkg::ST_LAG_START: begin
        priority if (bad) begin
          state_next = msd_pkg::ST_EMIT;
        end else if (first_origin_ok) begin
          state_next = msd_pkg::ST_ISSUE;
        end else begin
          state_next = msd_pkg::ST_DRAIN;
        end
      end
      msd_pkg::ST_ISSUE: begin
        if (last_j && last_origin) begin
          state_next = msd_pkg::ST_DRAIN;
        end
      end
      msd_pkg::ST_DRAIN: begin
        if (stg == '0) begin
          state_next = msd_pkg::ST_SCALE;
        end
      end
      msd_pkg::ST_SCALE: begin
        if (mcnt == 6'd1) begin
          state_next = msd_pkg::ST_DIV_START;
        end
      end
      msd_pkg::ST_DIV_START: state_next = msd_pkg::ST_DIV_WAIT;
      msd_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = msd_pkg::ST_EMIT;
        end
      end
      msd_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = (tau_next > {1'b0, lag_last}) ? msd_pkg::ST_IDLE
                                                     : msd_pkg::ST_LAG_START;
        end
      end
      default: state_next = msd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= '0;
    end else begin
      stg <= {stg[2:0], state == msd_pkg::ST_ISSUE};
    end
  end

  always_ff @(posedge clk) begin
    merged <= msd_pkg::ACC_W'(sq_x) + msd_pkg::ACC_W'(sq_y) + msd_pkg::ACC_W'(sq_z);
    if (stg[3]) begin
      acc <= acc + merged;
    end
    unique case (state)
      msd_pkg::ST_IDLE: begin
        if (run_fire) begin
          tau <= {1'b0, lag_first};
        end
      end
      msd_pkg::ST_LAG_START: begin
        err   <= bad;
        dspan <= dspan_c[msd_pkg::TAU_W-1:0];
        t0    <= {1'b0, frame_first};
        j     <= '0;
        acc   <= '0;
        num   <= '0;
        mcnt  <= fs;
      end
      msd_pkg::ST_ISSUE: begin
        if (last_j) begin
          j  <= '0;
          t0 <= t0_step[msd_pkg::TAU_W-1:0];
        end else begin
          j <= j + 1'b1;
        end
      end
      msd_pkg::ST_SCALE: begin
        num  <= num + msd_pkg::NUM_W'(acc);
        mcnt <= mcnt - 1'b1;
      end
      msd_pkg::ST_EMIT: begin
        if (out_free) begin
          tau <= tau_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == msd_pkg::ST_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == msd_pkg::ST_EMIT) && out_free) begin
      lag         <= tau[5:0];
      msd_value   <= err ? '0 : div_q;
      div_error   <= err;
      last_result <= (tau_next > {1'b0, lag_last});
    end
  end

  `MSD_ASSERT_NOW(a_count_cap, 1'b1, particle_count <= CAP, "particle count above capacity")
  `MSD_ASSERT_NOW(a_err_zero, out_valid && div_error, msd_value == '0, "error result not zero")
  `MSD_ASSERT_NEXT(a_run_busy, run_fire && (lag_first <= lag_last), !in_ready, "run not started")
  `MSD_ASSERT_NOW(a_issue_count, state == msd_pkg::ST_ISSUE, particle_count != '0, "walk with no particles")

endmodule

// ===== sim/mean_squared_displacement_test.sv =====
// ----------------------------------------------------------------------------
// mean_squared_displacement_test
// Loads small trajectories through the request channel, sweeps the lag with
// run requests and checks every result against an in-bench predictor of the
// time-averaged displacement. Registers are set over the APB port between
// phases; the sender runs in bursts and the receiver stalls on its own
// pattern, with one long hold-off against back-to-back run requests.
// ----------------------------------------------------------------------------
module mean_squared_displacement_test;

  localparam int NFRM       = 64;
  localparam int NPART      = 256;
  localparam int SETTLE     = 300;
  localparam int CYCLE_CAP  = 1000000;
  localparam int RAND_ITEMS = 110;

  typedef struct {
    logic [5:0]  lag;
    logic [62:0] val;
    logic        err;
    logic        last;
  } msd_result_t;

  class msd_predictor;
    logic [31:0]  store [NFRM*NPART*3];
    int           count, cur_frame;
    bit           overflow;
    int           r_type, r_lfirst, r_llast, r_lstride, r_ffirst, r_flast, r_fstride;
    msd_result_t  pending_msd [$];
    int           errors;

    function new();
      count = 0; cur_frame = 0; overflow = 0; errors = 0;
      r_type = 1; r_lfirst = 1; r_llast = 10; r_lstride = 1;
      r_ffirst = 0; r_flast = 63; r_fstride = 1;
    endfunction

    function void set_reg(logic [2:0] idx, int v);
      case (idx)
        msd_pkg::REG_TYPE:    r_type    = v & 8'hff;
        msd_pkg::REG_LFIRST:  r_lfirst  = v & 6'h3f;
        msd_pkg::REG_LLAST:   r_llast   = v & 6'h3f;
        msd_pkg::REG_LSTRIDE: r_lstride = v & 6'h3f;
        msd_pkg::REG_FFIRST:  r_ffirst  = v & 6'h3f;
        msd_pkg::REG_FLAST:   r_flast   = v & 6'h3f;
        msd_pkg::REG_FSTRIDE: r_fstride = v & 6'h3f;
        default: ;
      endcase
    endfunction

    function logic [127:0] lag_sum(int tau, int fs);
      logic [127:0] acc, m;
      longint d;
      acc = 0;
      for (int t0 = r_ffirst; t0 + tau <= r_flast; t0 += fs)
        for (int j = 0; j < count; j++)
          for (int k = 0; k < 3; k++) begin
            d = longint'($signed(store[((t0+tau)*NPART+j)*3+k]))
                - longint'($signed(store[(t0*NPART+j)*3+k]));
            m = (d < 0) ? -d : d;
            acc += m * m;
          end
      return acc;
    endfunction

    function void note_request(logic op, int fr, int ty, logic [31:0] x, y, z);
      int ls, fs, tau, nxt, dspan, n;
      logic [127:0] num, q;
      msd_result_t r;
      if (op == msd_pkg::OP_LOAD) begin
        if (fr > r_flast) return;
        if (fr != cur_frame) begin
          cur_frame = fr;
          count = 0;
        end
        if (ty != r_type) return;
        if (count >= NPART) begin
          overflow = 1;
          return;
        end
        store[(fr*NPART+count)*3+0] = x;
        store[(fr*NPART+count)*3+1] = y;
        store[(fr*NPART+count)*3+2] = z;
        count++;
        return;
      end
      ls = r_lstride ? r_lstride : 1;
      fs = r_fstride ? r_fstride : 1;
      tau = r_lfirst;
      n = 0;
      while (tau <= r_llast && n < 64) begin
        nxt = tau + ls;
        dspan = r_flast - r_ffirst + 1 - tau;
        r.lag = 6'(tau);
        r.val = 0;
        r.err = 0;
        if (dspan <= 0 || count == 0) begin
          r.err = 1;
        end else begin
          num = lag_sum(tau, fs) * fs;
          q = num / (128'(dspan) * 128'(count));
          r.val = (q > 128'h7fff_ffff_ffff_ffff) ? 63'h7fff_ffff_ffff_ffff : q[62:0];
        end
        r.last = (nxt > r_llast);
        pending_msd.push_back(r);
        n++;
        tau = nxt;
      end
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [5:0] lg, logic [62:0] v, logic e, logic l);
      msd_result_t w;
      if (pending_msd.size() == 0) begin
        report("unexpected result lag", lg, 0);
        return;
      end
      w = pending_msd.pop_front();
      if (lg !== w.lag)  report("lag", lg, w.lag);
      if (v !== w.val)   report("msd_value", v, w.val);
      if (e !== w.err)   report("div_error", e, w.err);
      if (l !== w.last)  report("last_result", l, w.last);
    endtask
  endclass

  logic               clk, rst;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               in_valid, in_ready, opcode;
  logic [5:0]         frame;
  logic [7:0]         atom_type;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic               out_valid, out_ready;
  logic [5:0]         lag;
  logic [62:0]        msd_value;
  logic               div_error, last_result;

  msd_predictor sb = new();
  int  cycles = 0;
  int  burst_left = 0;
  int  rand_sent = 0;
  int  hold_cnt = 0;
  bit  hold_req = 0;
  int  ready_mode = 0;

  mean_squared_displacement u_dut (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_result(lag, msd_value, div_error, last_result);

  always @(negedge clk) begin
    if (cycles % 64 == 0) ready_mode = $urandom_range(0, 2);
    if (hold_cnt > 0) begin
      out_ready = 0;
      hold_cnt--;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
      out_ready = 0;
    end else begin
      case (ready_mode)
        0: out_ready = 1;
        1: out_ready = 1'($urandom_range(0, 1));
        default: out_ready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task cfg_write(logic [2:0] idx, int v);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task send(logic op, int fr, int ty, logic [31:0] x, y, z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1; opcode = op; frame = 6'(fr); atom_type = 8'(ty);
    pos_x = x; pos_y = y; pos_z = z;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, fr, ty, x, y, z);
  endtask

  task drain();
    @(negedge clk);
    in_valid = 0;
    wait (sb.pending_msd.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function logic [31:0] rand_pos();
    if ($urandom_range(0, 1)) return $urandom;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // ext: alternate extreme positions by frame parity
  // zero_tail: finish with a foreign-type record in frame 0 to empty the count
  // pressure: hold the receiver and offer a second run behind the first
  task msd_phase(int ts, lf, ll, ls, ff, fl, fs, n, bit ext, zero_tail, pressure, noise);
    logic [31:0] p;
    int other;
    cfg_write(msd_pkg::REG_TYPE, ts);
    cfg_write(msd_pkg::REG_LFIRST, lf);
    cfg_write(msd_pkg::REG_LLAST, ll);
    cfg_write(msd_pkg::REG_LSTRIDE, ls);
    cfg_write(msd_pkg::REG_FFIRST, ff);
    cfg_write(msd_pkg::REG_FLAST, fl);
    cfg_write(msd_pkg::REG_FSTRIDE, fs);
    other = (ts % 255) + 1;
    for (int f = 0; f <= fl; f++)
      for (int j = 0; j < n; j++) begin
        if (noise && $urandom_range(0, 5) == 0)
          send(msd_pkg::OP_LOAD, f, other, $urandom, $urandom, $urandom);
        if (noise && fl < 63 && $urandom_range(0, 7) == 0)
          send(msd_pkg::OP_LOAD, $urandom_range(fl + 1, 63), ts, $urandom, $urandom,
               $urandom);
        p = f[0] ? 32'h7fff_ffff : 32'h8000_0000;
        if (ext) send(msd_pkg::OP_LOAD, f, ts, p, p, p);
        else send(msd_pkg::OP_LOAD, f, ts, rand_pos(), rand_pos(), rand_pos());
        rand_sent++;
      end
    if (zero_tail) send(msd_pkg::OP_LOAD, 0, other, 0, 0, 0);
    if (pressure) hold_req = 1;
    send(msd_pkg::OP_RUN, $urandom_range(0, 63), $urandom_range(0, 255), $urandom, $urandom,
         $urandom);
    if (pressure) send(msd_pkg::OP_RUN, $urandom, $urandom, $urandom, $urandom, $urandom);
    drain();
  endtask

  initial begin
    int fl, n;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; opcode = 0; frame = 0; atom_type = 1;
    pos_x = 0; pos_y = 0; pos_z = 0; out_ready = 0;
    repeat (2) @(negedge clk);
    rst = 0;
    msd_phase(1, 1, 1, 1, 0, 1, 1, 1, 1, 0, 0, 0);
    msd_phase(255, 0, 3, 1, 0, 2, 1, 2, 0, 1, 0, 1);
    msd_phase(7, 5, 2, 1, 0, 3, 1, 1, 0, 0, 0, 0);
    msd_phase(9, 0, 4, 1, 3, 2, 1, 1, 0, 0, 0, 0);
    msd_phase(3, 0, 5, 0, 0, 4, 0, 2, 0, 0, 0, 1);
    msd_phase(200, 63, 63, 63, 0, 63, 63, 1, 0, 0, 0, 0);
    msd_phase(5, 0, 6, 1, 0, 5, 1, 3, 0, 0, 1, 1);
    while (rand_sent < RAND_ITEMS) begin
      fl = $urandom_range(1, 12);
      n = $urandom_range(1, 4);
      msd_phase($urandom_range(1, 255), $urandom_range(0, 15),
                $urandom_range(0, 4) ? $urandom_range(0, 20) : 63,
                $urandom_range(0, 6) ? $urandom_range(1, 4) : 63,
                $urandom_range(0, 5) ? $urandom_range(0, fl) : $urandom_range(0, 63),
                fl, $urandom_range(0, 6) ? $urandom_range(1, 3) : 63, n,
                0, $urandom_range(0, 9) == 0, 0, 1);
    end
    drain();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
